// ===== sv/aes128_cbc_block_cipher_defines.svh =====
// Assertion macros shared by the AES-128 CBC block.
`ifndef AES128_CBC_BLOCK_CIPHER_DEFINES_SVH
`define AES128_CBC_BLOCK_CIPHER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define ACBC_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ACBC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/acbc_pkg.sv =====
// Types, constants and GF(2^8) helpers for the AES-128 CBC block.
package acbc_pkg;

   localparam int unsigned RoundCount = 10;
   localparam int unsigned RoundBits  = 4;
   localparam int unsigned KeyCount   = RoundCount + 1;

   localparam logic [2:0] CsrKeyHigh  = 3'd0;
   localparam logic [2:0] CsrKeyLow   = 3'd1;
   localparam logic [2:0] CsrIvHigh   = 3'd2;
   localparam logic [2:0] CsrIvLow    = 3'd3;
   localparam logic [2:0] CsrDecrypt  = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                 load;      // capture request, add round key 0 or 10
      logic                 round;     // run one round
      logic                 last;      // final round (no mix)
      logic [RoundBits-1:0] key_idx;   // round key for this cycle
      logic                 finish;    // apply chain and update it
      logic                 kx_start;  // begin key expansion
      logic                 kx_step;   // one expansion step
   } acbc_cmd_type;

   typedef struct packed {
      logic                 decrypt;
   } acbc_stat_type;

   localparam logic [7:0] Rcon [KeyCount] = '{8'h8d, 8'h01, 8'h02, 8'h04, 8'h08,
      8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   localparam logic [7:0] Sbox [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] InvSbox [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   // xtime: multiply by x in GF(2^8)
   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Multiply by a constant of the inverse mix (0x09, 0x0b, 0x0d, 0x0e)
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] a2, a4, a8, r;
      a2 = xt(a);
      a4 = xt(a2);
      a8 = xt(a4);
      r  = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
         ^ (b[3] ? a8 : 8'h00);
      return r;
   endfunction

endpackage

// ===== sv/acbc_ctrl.sv =====
// Controller sequencing key expansion and the cipher rounds.
module acbc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  csr_key_write,
   input  acbc_pkg::acbc_stat_type stat,
   output acbc_pkg::acbc_cmd_type  cmd
);
   import acbc_pkg::*;

   `include "aes128_cbc_block_cipher_defines.svh"

   typedef enum logic [1:0] {IDLE, ROUND, KEYEXP} state_type;

   state_type            state_ff, state_in;
   logic [RoundBits-1:0] cnt_ff, cnt_in;
   logic                 dec_ff, dec_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept, done, free_out;

   // Output register frees when it is empty or being taken
   assign free_out  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE) && !csr_key_write;
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == ROUND) && (cnt_ff == RoundBits'(RoundCount))
                      && free_out;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dec_in       = dec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (csr_key_write) begin
               cmd.kx_start = 1'b1;
               cnt_in       = RoundBits'(1);
               state_in     = KEYEXP;
            end else if (accept) begin
               cmd.load    = 1'b1;
               cmd.key_idx = stat.decrypt ? RoundBits'(RoundCount) : '0;
               dec_in      = stat.decrypt;
               cnt_in      = RoundBits'(1);
               state_in    = ROUND;
            end
         end
         ROUND: begin
            // Last round waits until the output register is free
            cmd.key_idx = dec_ff ? RoundBits'(RoundCount) - cnt_ff : cnt_ff;
            cmd.last    = cnt_ff == RoundBits'(RoundCount);
            if (cnt_ff != RoundBits'(RoundCount) || free_out) begin
               cmd.round = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (done) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         KEYEXP: begin
            // A new key write restarts the expansion from the updated key
            if (csr_key_write) begin
               cmd.kx_start = 1'b1;
               cnt_in       = RoundBits'(1);
            end else begin
               cmd.kx_step = 1'b1;
               cmd.key_idx = cnt_ff;
               cnt_in      = cnt_ff + 1'b1;
               if (cnt_ff == RoundBits'(RoundCount)) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ACBC_ASSERT_NEXT(a_accept_runs, clock, reset, accept, state_ff == ROUND,
      "accepted request did not start rounds")
   `ACBC_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != IDLE, !req_ready,
      "ready while busy")
   `ACBC_ASSERT_NEXT(a_done_valid, clock, reset, done, rsp_valid_ff,
      "finished block not presented")
   `ACBC_ASSERT_IMP(a_round_idx, clock, reset, state_ff == ROUND,
      cnt_ff != '0 && cnt_ff <= RoundBits'(RoundCount), "round count out of range")

endmodule

// ===== sv/acbc_datapath.sv =====
// Round datapath, key schedule storage, chaining and output register.
module acbc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_write_data,
   input  logic [63:0]            req_block_high,
   input  logic [63:0]            req_block_low,
   input  logic                   req_first_block,
   output logic [63:0]            rsp_result_high,
   output logic [63:0]            rsp_result_low,
   input  acbc_pkg::acbc_cmd_type cmd,
   output acbc_pkg::acbc_stat_type stat
);
   import acbc_pkg::*;

   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic         dec_ff;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] cin_ff;       // ciphertext input kept for decrypt chaining
   logic [127:0] out_ff;
   logic [127:0] rk_ff [KeyCount];
   logic [127:0] rkey, kx_prev, kx_next, blk, chain_use;
   logic [7:0]   sb [16];
   logic [7:0]   ss [16];
   logic [7:0]   ms [16];
   logic [127:0] fwd_res, inv_res, inv_add;
   logic [31:0]  tw;

   // Byte k of a 128-bit word: byte 0 is the top
   function automatic logic [7:0] byt(input logic [127:0] w, input int k);
      return w[127-8*k -: 8];
   endfunction

   assign stat.decrypt = dec_ff;
   assign rkey         = rk_ff[cmd.key_idx];
   assign blk          = {req_block_high, req_block_low};
   assign chain_use    = chain_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         iv_hi_ff  <= '0;
         iv_lo_ff  <= '0;
         dec_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrKeyHigh: key_hi_ff <= csr_write_data;
            CsrKeyLow:  key_lo_ff <= csr_write_data;
            CsrIvHigh:  iv_hi_ff  <= csr_write_data;
            CsrIvLow:   iv_lo_ff  <= csr_write_data;
            CsrDecrypt: dec_ff    <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // One key expansion step: round key i from round key i-1
   assign kx_prev = rk_ff[cmd.key_idx - 1'b1];
   always_comb begin
      tw = {Sbox[kx_prev[23:16]] ^ Rcon[cmd.key_idx], Sbox[kx_prev[15:8]],
            Sbox[kx_prev[7:0]], Sbox[kx_prev[31:24]]};
      kx_next[127:96] = kx_prev[127:96] ^ tw;
      kx_next[95:64]  = kx_prev[95:64]  ^ kx_next[127:96];
      kx_next[63:32]  = kx_prev[63:32]  ^ kx_next[95:64];
      kx_next[31:0]   = kx_prev[31:0]   ^ kx_next[63:32];
   end

   always_ff @(posedge clock) begin
      if (cmd.kx_start) begin
         rk_ff[0] <= (csr_index == CsrKeyHigh) ? {csr_write_data, key_lo_ff}
                                                : {key_hi_ff, csr_write_data};
      end else if (cmd.kx_step) begin
         rk_ff[cmd.key_idx] <= kx_next;
      end
   end

   // Forward and inverse round logic
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (dec_ff) begin
               ss[((c + r) % 4) * 4 + r] = InvSbox[byt(st_ff, c * 4 + r)];
            end else begin
               ss[c * 4 + r] = Sbox[byt(st_ff, ((c + r) % 4) * 4 + r)];
            end
         end
      end
      for (int k = 0; k < 16; k++) begin
         sb[k] = ss[k] ^ byt(rkey, k);
      end
      for (int c = 0; c < 4; c++) begin
         if (dec_ff) begin
            ms[c*4]   = gmul(sb[c*4], 4'he) ^ gmul(sb[c*4+1], 4'hb)
                      ^ gmul(sb[c*4+2], 4'hd) ^ gmul(sb[c*4+3], 4'h9);
            ms[c*4+1] = gmul(sb[c*4], 4'h9) ^ gmul(sb[c*4+1], 4'he)
                      ^ gmul(sb[c*4+2], 4'hb) ^ gmul(sb[c*4+3], 4'hd);
            ms[c*4+2] = gmul(sb[c*4], 4'hd) ^ gmul(sb[c*4+1], 4'h9)
                      ^ gmul(sb[c*4+2], 4'he) ^ gmul(sb[c*4+3], 4'hb);
            ms[c*4+3] = gmul(sb[c*4], 4'hb) ^ gmul(sb[c*4+1], 4'hd)
                      ^ gmul(sb[c*4+2], 4'h9) ^ gmul(sb[c*4+3], 4'he);
         end else begin
            ms[c*4]   = ss[c*4]   ^ (ss[c*4]^ss[c*4+1]^ss[c*4+2]^ss[c*4+3])
                      ^ xt(ss[c*4] ^ ss[c*4+1]);
            ms[c*4+1] = ss[c*4+1] ^ (ss[c*4]^ss[c*4+1]^ss[c*4+2]^ss[c*4+3])
                      ^ xt(ss[c*4+1] ^ ss[c*4+2]);
            ms[c*4+2] = ss[c*4+2] ^ (ss[c*4]^ss[c*4+1]^ss[c*4+2]^ss[c*4+3])
                      ^ xt(ss[c*4+2] ^ ss[c*4+3]);
            ms[c*4+3] = ss[c*4+3] ^ (ss[c*4]^ss[c*4+1]^ss[c*4+2]^ss[c*4+3])
                      ^ xt(ss[c*4+3] ^ ss[c*4]);
         end
      end
      for (int k = 0; k < 16; k++) begin
         fwd_res[127-8*k -: 8] = ms[k] ^ byt(rkey, k);
         inv_res[127-8*k -: 8] = ms[k];
         inv_add[127-8*k -: 8] = sb[k];
      end
   end

   // State register: load with whitening, then one round per command
   always_comb begin
      st_in    = st_ff;
      chain_in = chain_ff;
      if (cmd.load) begin
         if (req_first_block) begin
            chain_in = {iv_hi_ff, iv_lo_ff};
         end
         st_in = (dec_ff ? blk : blk ^ (req_first_block ? {iv_hi_ff, iv_lo_ff}
                                                         : chain_ff)) ^ rkey;
      end else if (cmd.round) begin
         if (cmd.last) begin
            st_in = inv_add;
         end else begin
            st_in = dec_ff ? inv_res : fwd_res;
         end
      end
      if (cmd.finish) begin
         chain_in = dec_ff ? cin_ff : inv_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (cmd.load) begin
         cin_ff <= blk;
      end
      if (cmd.finish) begin
         out_ff <= dec_ff ? inv_add ^ chain_use : inv_add;
      end
   end

   assign rsp_result_high = out_ff[127:64];
   assign rsp_result_low  = out_ff[63:0];

endmodule

// ===== sv/aes128_cbc_block_cipher.sv =====
// Top level of the AES-128 CBC block cipher.
// Usage:
//   Write key_high/key_low (csr index 0/1), the IV (2/3) and decrypt_mode (4)
//   on the csr_ port while the block is idle. Each key write starts a key
//   expansion, one round key per cycle; no request is taken then.
//   A key write during an expansion restarts it with the updated key.
//   A request carries one 128-bit block and first_block, which reloads the
//   chain from the IV. Encrypt: out = E(in ^ chain), chain = out. Decrypt:
//   out = D(in) ^ chain, chain = in.
//   The accepting edge loads the block with the first key addition, the
//   rounds follow through the shared round unit, and the last round
//   registers the result and raises rsp_valid. One request is processed
//   at a time, so a new request is taken the cycle after the last round.
//   The response waits in its register until rsp_ready; a further block may
//   be processed meanwhile, holding in its last round until the register frees.
//   Reset clears the configuration, chain and control; round keys are
//   undefined until a key register is written.
module aes128_cbc_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic        req_first_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import acbc_pkg::*;

   acbc_cmd_type  cmd;
   acbc_stat_type stat;
   logic          key_write;

   assign key_write = csr_write_enable
                      && (csr_index == CsrKeyHigh || csr_index == CsrKeyLow);

   acbc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .csr_key_write (key_write),
      .stat          (stat),
      .cmd           (cmd)
   );

   acbc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_block_high   (req_block_high),
      .req_block_low    (req_block_low),
      .req_first_block  (req_first_block),
      .rsp_result_high  (rsp_result_high),
      .rsp_result_low   (rsp_result_low),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
